@@ sv/glyph_row_rasterizer_top_defines.svh @@
// Assertion macros shared by the glyph row rasterizer RTL.
`ifndef GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH
`define GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph row rasterizer: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph row rasterizer: next-cycle check failed");

`endif

@@ sv/grr_pkg.sv @@
// Shared constants and codes of the glyph row rasterizer.
package grr_pkg;

  localparam int GLYPH_COUNT_DEFAULT     = 256;
  localparam int BYTES_PER_PIXEL_DEFAULT = 4;

  localparam int ROWS_PER_GLYPH  = 16;
  localparam int ROW_W           = 4;
  localparam int BASELINE_OFFSET = 12;

  localparam int COORD_W = 13;
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 15;

  localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd480;
  localparam logic [14:0] LINE_PITCH_RESET    = 15'd2560;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_LINE_PITCH    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

endpackage

@@ sv/grr_font_ram.sv @@
// Font store: single write port, single registered read port.
module grr_font_ram #(
  parameter int DEPTH   = grr_pkg::GLYPH_COUNT_DEFAULT * grr_pkg::ROWS_PER_GLYPH,
  parameter int FADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [FADDR_W-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               rd_en,
  input  logic [FADDR_W-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps its byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/glyph_row_rasterizer_top.sv @@
// Top level of the 8x16 glyph row rasterizer.
// Usage. Items arrive on the s_axis channel; tuser carries the command. A load
// item writes one font byte into the on-chip font store and produces nothing.
// A draw item produces sixteen row transfers on m_axis, top row first, with
// tlast set on the sixteenth. Each row transfer carries the framebuffer byte
// address of its leftmost pixel, an 8-bit write mask that clears off-screen
// pixels, and eight 24-bit colors (foreground for set font bits, background
// for clear ones, leftmost pixel in the lowest slot).
// Rate. The first row of a draw passes through the draw context registers,
// the font read stage and the output register; after that one row is produced
// per cycle while m_axis_tready stays high, set by the single font store read
// port that fetches one row byte per cycle. s_axis_tready stays low while the
// row reads of a draw are issued, so no new item is taken until they are done.
// Loads do not hold s_axis_tready low and are taken back to back while idle.
// Stalls. When m_axis_tready is low, the output register and the font read
// stage hold their contents and row reads stop once the read stage is full.
// Reset. rst (synchronous, active high) empties the pipeline and restores the
// screen registers to 640 by 480 with a 2560-byte pitch. The font store is not
// cleared and must be loaded before a glyph is drawn. The configuration port
// must be written only while the block is idle; the block does not enforce it.
`include "glyph_row_rasterizer_top_defines.svh"

module glyph_row_rasterizer_top #(
  parameter int GLYPH_COUNT     = grr_pkg::GLYPH_COUNT_DEFAULT,
  parameter int BYTES_PER_PIXEL = grr_pkg::BYTES_PER_PIXEL_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  // Input item stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0 up: glyph_code[7:0], font_row[11:8], font_byte[19:12],
  // pos_x[32:20], pos_y[45:33], fg_color[69:46], bg_color[93:70],
  // buffer_base[125:94], zero fill[127:126].
  input  logic [127:0] s_axis_tdata,
  // tuser: command (0 load, 1 draw).
  input  logic [0:0]   s_axis_tuser,
  // Row result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0 up: row_address[31:0], write_mask[39:32],
  // pixel_0[63:40] through pixel_7[231:208], 24 bits per pixel.
  output logic [231:0] m_axis_tdata,
  // tlast: last_row.
  output logic         m_axis_tlast
);

  localparam int FONT_DEPTH = GLYPH_COUNT * grr_pkg::ROWS_PER_GLYPH;
  localparam int FADDR_W    = $clog2(FONT_DEPTH);
  localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);
  localparam logic [2:0] BPP         = 3'(BYTES_PER_PIXEL);
  localparam logic [grr_pkg::ROW_W-1:0] LAST_ROW =
    grr_pkg::ROW_W'(grr_pkg::ROWS_PER_GLYPH - 1);
  localparam logic signed [13:0] BASELINE = 14'(grr_pkg::BASELINE_OFFSET);

  // Input fields.
  logic                                 in_cmd;
  logic [7:0]                           in_code;
  logic [3:0]                           in_row;
  logic [7:0]                           in_byte;
  logic signed [grr_pkg::COORD_W-1:0]   in_x;
  logic signed [grr_pkg::COORD_W-1:0]   in_y;
  logic [grr_pkg::COLOR_W-1:0]          in_fg;
  logic [grr_pkg::COLOR_W-1:0]          in_bg;
  logic [grr_pkg::ADDR_W-1:0]           in_base;

  assign in_cmd  = s_axis_tuser[0];
  assign in_code = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[11:8];
  assign in_byte = s_axis_tdata[19:12];
  assign in_x    = $signed(s_axis_tdata[32:20]);
  assign in_y    = $signed(s_axis_tdata[45:33]);
  assign in_fg   = s_axis_tdata[69:46];
  assign in_bg   = s_axis_tdata[93:70];
  assign in_base = s_axis_tdata[125:94];

  // Screen registers.
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [14:0] line_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= grr_pkg::SCREEN_WIDTH_RESET;
      screen_height <= grr_pkg::SCREEN_HEIGHT_RESET;
      line_pitch    <= grr_pkg::LINE_PITCH_RESET;
    end else if (cfg_we) begin
      case (grr_pkg::reg_index_t'(cfg_index))
        grr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        grr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        grr_pkg::REG_LINE_PITCH:    line_pitch    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and draw context.
  logic                       active;
  logic [grr_pkg::ROW_W-1:0]  row;
  logic [7:0]                 it_code;
  logic                       it_ok;
  logic [23:0]                it_fg;
  logic [23:0]                it_bg;
  logic [31:0]                it_xbase;
  logic [31:0]                it_yoff;
  logic signed [13:0]         it_ry;
  logic [7:0]                 it_xmask;

  // Font read stage.
  logic        s1_valid;
  logic [31:0] s1_addr;
  logic [7:0]  s1_mask;
  logic        s1_last;
  logic        s1_ok;
  logic [23:0] s1_fg;
  logic [23:0] s1_bg;
  logic [7:0]  rd_data;

  // Output register.
  logic         out_valid;
  logic [231:0] out_data;
  logic         out_last;

  logic accept;
  logic code_ok;
  logic wr_en;
  logic out_free;
  logic issue;
  logic row_ok;
  logic [FADDR_W-1:0] wr_addr;
  logic [FADDR_W-1:0] rd_addr;

  assign s_axis_tready = !active;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign code_ok  = {1'b0, in_code} < GLYPH_LIMIT;
  assign wr_en    = accept && (grr_pkg::cmd_t'(in_cmd) == grr_pkg::CMD_LOAD) && code_ok;
  assign wr_addr  = FADDR_W'({in_code, in_row});
  assign out_free = !out_valid || m_axis_tready;
  assign issue    = active && (!s1_valid || out_free);
  assign rd_addr  = FADDR_W'({it_code, row});
  assign row_ok   = !it_ry[13] && (it_ry[12:0] < screen_height);

  // Draw set-up terms computed from the incoming item.
  logic signed [13:0] start_ry;
  logic signed [29:0] yprod;
  logic signed [16:0] xprod;
  logic [7:0]         xmask;

  assign start_ry = 14'(in_y) - BASELINE;
  assign yprod    = 30'(start_ry) * 30'($signed({1'b0, line_pitch}));
  assign xprod    = 17'(in_x) * 17'($signed({1'b0, BPP}));

  // A column is visible when it is non-negative and left of the screen edge.
  always_comb begin
    logic signed [13:0] cx;
    for (int i = 0; i < 8; i++) begin
      cx = 14'(in_x) + 14'(i);
      xmask[i] = !cx[13] && (cx[12:0] < screen_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
    end else if (accept && (grr_pkg::cmd_t'(in_cmd) == grr_pkg::CMD_DRAW)) begin
      active <= 1'b1;
      row    <= '0;
    end else if (issue) begin
      row <= row + 1'b1;
      if (row == LAST_ROW) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_code  <= in_code;
      it_ok    <= code_ok;
      it_fg    <= in_fg;
      it_bg    <= in_bg;
      it_xbase <= in_base + {{15{xprod[16]}}, xprod};
      it_yoff  <= {{2{yprod[29]}}, yprod};
      it_ry    <= start_ry;
      it_xmask <= xmask;
    end else if (issue) begin
      it_yoff <= it_yoff + 32'(line_pitch);
      it_ry   <= it_ry + 14'sd1;
    end
  end

  grr_font_ram #(
    .DEPTH   (FONT_DEPTH),
    .FADDR_W (FADDR_W)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The read stage carries its own copy of the draw context so that the next
  // draw can load new context while this row is still waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_valid && out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr <= it_xbase + it_yoff;
      s1_mask <= row_ok ? it_xmask : 8'h00;
      s1_last <= (row == LAST_ROW);
      s1_ok   <= it_ok;
      s1_fg   <= it_fg;
      s1_bg   <= it_bg;
    end
  end

  // Expand the font byte: bit 7 is the leftmost pixel. A glyph beyond the
  // store draws as background only.
  logic [191:0] pixels;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pixels[i*24 +: 24] = (s1_ok && rd_data[7-i]) ? s1_fg : s1_bg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      out_data <= {pixels, s1_mask, s1_addr};
      out_last <= s1_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // The row counter rests at zero between draws.
  `GRR_ASSERT_NOW(a_row_idle, !active, row == '0)
  // Font writes and row reads never share a cycle.
  `GRR_ASSERT_NOW(a_no_rw_overlap, wr_en, !issue)
  // A stalled read stage keeps its font byte.
  `GRR_ASSERT_NEXT(a_read_hold, s1_valid && !out_free, s1_valid && $stable(rd_data))
  // Issuing the last row read ends the draw.
  `GRR_ASSERT_NEXT(a_last_issue, issue && (row == LAST_ROW), !active && s1_last)

endmodule
